@@ sv/rsim_pkg.sv @@
// Package of the ring slot index manager.
// Holds field widths, command and status codes, controller states and the
// control structs shared by the controller and the datapath. No dependencies.
`default_nettype none

package rsim_pkg;

  localparam int IDX_W = 10;
  localparam int CNT_W = 11;
  localparam int CMD_W = 2;
  localparam int STS_W = 2;

  localparam logic [CNT_W-1:0] MAX_SLOTS = CNT_W'(1024);
  localparam logic [CNT_W-1:0] MIN_SLOTS = CNT_W'(2);
  localparam logic [CNT_W-1:0] RESET_SLOTS = CNT_W'(1024);

  // One remainder bit is produced per dividend bit.
  localparam int MOD_STEPS = CNT_W;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_COMMIT  = 2'd1,
    CMD_CONSUME = 2'd2,
    CMD_DISPOSE = 2'd3
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RETRY = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_MOD  = 1'b1
  } ctrl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic exec;        // apply a request handled without the remainder unit and load the result
    logic mod_start;   // start the remainder of commit_next by the slot count
    logic mod_finish;  // store the remainder as the commit index, load result
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_valid;
    logic commit_slow;
    logic mod_done;
  } dp_status_t;

endpackage

`default_nettype wire

@@ sv/rsim_ifs.sv @@
// Handshake interfaces of the ring slot index manager: request and response.
// Depends on rsim_pkg for the field widths.
`default_nettype none

interface rsim_req_if import rsim_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] commit_prev;
  logic [CNT_W-1:0] commit_next;

  modport source (output valid, output cmd, output commit_prev, output commit_next,
                  input ready);
  modport sink (input valid, input cmd, input commit_prev, input commit_next,
                output ready);
endinterface

interface rsim_rsp_if import rsim_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [STS_W-1:0] status;
  logic [IDX_W-1:0] slot;
  logic [CNT_W-1:0] next_raw;

  modport source (output valid, output status, output slot, output next_raw,
                  input ready);
  modport sink (input valid, input status, input slot, input next_raw,
                output ready);
endinterface

`default_nettype wire

@@ sv/rsim_mod_unit.sv @@
// Bit-serial remainder unit: dividend modulo divisor, one bit per cycle.
// Depends on rsim_pkg. Used by the datapath for commit wrapping.
`default_nettype none

module rsim_mod_unit import rsim_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [CNT_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  done,
  output logic [IDX_W-1:0]      rem
);

  localparam logic [MOD_CNT_W-1:0] LAST_STEP = MOD_CNT_W'(MOD_STEPS - 1);

  logic                 busy;
  logic [MOD_CNT_W-1:0] step;
  logic [CNT_W-1:0]     dvd;
  logic [CNT_W-1:0]     dvs;
  logic [CNT_W-1:0]     trial;

  // The partial remainder stays below the divisor, which is at most 1024,
  // so it fits the index width and the trial value fits the count width.
  assign trial = {rem, dvd[CNT_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + MOD_CNT_W'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[CNT_W-2:0], 1'b0};
      if (trial >= dvs) begin
        rem <= IDX_W'(trial - dvs);
      end else begin
        rem <= trial[IDX_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/rsim_datapath.sv @@
// Datapath of the ring slot index manager: slot count register, the four
// ring indices, the remainder unit and the response register.
// Depends on rsim_pkg and rsim_mod_unit.
`default_nettype none

module rsim_datapath import rsim_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  input  wire logic [CMD_W-1:0] req_cmd,
  input  wire logic [IDX_W-1:0] req_commit_prev,
  input  wire logic [CNT_W-1:0] req_commit_next,
  input  wire logic             rsp_ready,
  input  wire ctrl_cmd_t        ctrl,
  output dp_status_t            stat,
  output logic                  rsp_valid,
  output status_t               rsp_status,
  output logic [IDX_W-1:0]      rsp_slot,
  output logic [CNT_W-1:0]      rsp_next_raw
);

  logic [CNT_W-1:0] slot_count;
  logic [IDX_W-1:0] acquire_index;
  logic [IDX_W-1:0] commit_index;
  logic [IDX_W-1:0] consume_index;
  logic [IDX_W-1:0] dispose_index;

  logic [IDX_W-1:0] acquire_index_next;
  logic [IDX_W-1:0] commit_index_next;
  logic [IDX_W-1:0] consume_index_next;
  logic [IDX_W-1:0] dispose_index_next;

  logic [CNT_W-1:0] eff_count;
  logic [CNT_W-1:0] acq_inc;
  logic             grant;
  logic             commit_match;
  cmd_t             cmd;
  status_t          res_status;
  logic [IDX_W-1:0] res_slot;
  logic [CNT_W-1:0] res_next_raw;
  logic             mod_done;
  logic [IDX_W-1:0] mod_rem;

  function automatic logic [IDX_W-1:0] step_wrap(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] n;
    n = {1'b0, idx} + CNT_W'(1);
    return (n >= cnt) ? '0 : n[IDX_W-1:0];
  endfunction

  assign cmd = cmd_t'(req_cmd);

  always_comb begin
    if (slot_count < MIN_SLOTS) begin
      eff_count = MIN_SLOTS;
    end else if (slot_count > MAX_SLOTS) begin
      eff_count = MAX_SLOTS;
    end else begin
      eff_count = slot_count;
    end
  end

  assign acq_inc = {1'b0, acquire_index} + CNT_W'(1);

  // An acquire behind the dispose index may not catch up with it; otherwise
  // it may wrap to zero only while slot zero has been freed.
  always_comb begin
    if (acquire_index < dispose_index) begin
      grant = acq_inc < {1'b0, dispose_index};
    end else begin
      grant = (acq_inc < eff_count) || (dispose_index != '0);
    end
  end

  assign commit_match = (commit_index == req_commit_prev);

  always_comb begin
    acquire_index_next = acquire_index;
    commit_index_next  = commit_index;
    consume_index_next = consume_index;
    dispose_index_next = dispose_index;
    res_status   = ST_DONE;
    res_slot     = '0;
    res_next_raw = '0;
    unique case (cmd)
      CMD_ACQUIRE: begin
        if (grant) begin
          acquire_index_next = (acq_inc >= eff_count) ? '0 : acq_inc[IDX_W-1:0];
          res_slot     = acquire_index;
          res_next_raw = acq_inc;
        end else begin
          res_status = ST_RETRY;
        end
      end
      CMD_COMMIT: begin
        if (commit_match) begin
          // Below the count the value is already wrapped; larger values go
          // through the remainder unit instead of this path.
          commit_index_next = req_commit_next[IDX_W-1:0];
        end else begin
          res_status = ST_RETRY;
        end
      end
      CMD_CONSUME: begin
        if (consume_index == commit_index) begin
          res_status = ST_EMPTY;
        end else begin
          res_slot           = consume_index;
          consume_index_next = step_wrap(consume_index, eff_count);
        end
      end
      CMD_DISPOSE: begin
        if (dispose_index == commit_index) begin
          res_status = ST_EMPTY;
        end else begin
          dispose_index_next = step_wrap(dispose_index, eff_count);
        end
      end
      default: begin
        res_status = ST_DONE;
      end
    endcase
  end

  rsim_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.mod_start),
    .dividend (req_commit_next),
    .divisor  (eff_count),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count    <= RESET_SLOTS;
      acquire_index <= '0;
      commit_index  <= '0;
      consume_index <= '0;
      dispose_index <= '0;
    end else if (cfg_we) begin
      slot_count    <= cfg_wdata;
      acquire_index <= '0;
      commit_index  <= '0;
      consume_index <= '0;
      dispose_index <= '0;
    end else if (ctrl.exec) begin
      acquire_index <= acquire_index_next;
      commit_index  <= commit_index_next;
      consume_index <= consume_index_next;
      dispose_index <= dispose_index_next;
    end else if (ctrl.mod_finish) begin
      commit_index <= mod_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.exec || ctrl.mod_finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      rsp_status   <= res_status;
      rsp_slot     <= res_slot;
      rsp_next_raw <= res_next_raw;
    end else if (ctrl.mod_finish) begin
      rsp_status   <= ST_DONE;
      rsp_slot     <= '0;
      rsp_next_raw <= '0;
    end
  end

  assign stat.out_valid   = rsp_valid;
  assign stat.commit_slow = (cmd == CMD_COMMIT) && commit_match &&
                            (req_commit_next >= eff_count);
  assign stat.mod_done    = mod_done;

endmodule

`default_nettype wire

@@ sv/rsim_ctrl.sv @@
// Controller of the ring slot index manager: request handshake and the
// sequencing of commits that need the remainder unit. Depends on rsim_pkg.
`default_nettype none

module rsim_ctrl import rsim_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  input  wire logic       rsp_ready,
  input  wire dp_status_t stat,
  output logic            req_ready,
  output ctrl_cmd_t       ctrl
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        accept;

  assign accept = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && stat.commit_slow) begin
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (stat.mod_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // In the idle state a request is taken when the response register is free or is
  // being emptied in the same cycle; none is taken while the remainder unit runs.
  always_comb begin
    req_ready       = 1'b0;
    ctrl.exec       = 1'b0;
    ctrl.mod_start  = 1'b0;
    ctrl.mod_finish = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready      = !stat.out_valid || rsp_ready;
        ctrl.exec      = accept && !stat.commit_slow;
        ctrl.mod_start = accept && stat.commit_slow;
      end
      S_MOD: begin
        ctrl.mod_finish = stat.mod_done;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/ring_slot_index_manager_unit.sv @@
// Ring slot index manager: keeps the acquire, commit, consume and dispose
// indices of a ring and answers one response per request. Acquire, consume,
// dispose and an in-order commit whose next value is already below the slot
// count need no remainder unit, so such requests stream at one per cycle
// while each response is taken. A commit whose next value must be wrapped
// goes through a bit-serial remainder unit that handles one bit of
// commit_next per cycle, and no request is taken until its response is
// loaded. Writing the slot count clears all four indices.
// Depends on rsim_pkg, rsim_ifs, rsim_ctrl and rsim_datapath.
`default_nettype none

module ring_slot_index_manager_unit import rsim_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  rsim_req_if.sink              req,
  rsim_rsp_if.source            rsp
);

  ctrl_cmd_t  ctrl;
  dp_status_t stat;
  status_t    rsp_status;

  rsim_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .req_ready (req.ready),
    .ctrl      (ctrl)
  );

  rsim_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .req_cmd         (req.cmd),
    .req_commit_prev (req.commit_prev),
    .req_commit_next (req.commit_next),
    .rsp_ready       (rsp.ready),
    .ctrl            (ctrl),
    .stat            (stat),
    .rsp_valid       (rsp.valid),
    .rsp_status      (rsp_status),
    .rsp_slot        (rsp.slot),
    .rsp_next_raw    (rsp.next_raw)
  );

  assign rsp.status = rsp_status;

endmodule

`default_nettype wire
